FILE: sv/lbsa_pkg.sv
`default_nettype none
package lbsa_pkg;
  localparam int SW = 24;
  localparam int SUMW = 40;
  localparam int CSTEPS = 16;
  localparam int MAX_BINS = 65536;

  localparam logic [4:0] REG_LOG_BASE = 5'd0;
  localparam logic [4:0] REG_NUM_BINS = 5'd1;
  localparam logic [4:0] REG_SPACING  = 5'd2;

  typedef struct packed {
    logic signed [SUMW-1:0] sr;
    logic signed [SUMW-1:0] si;
    logic [16:0]            count;
    logic [15:0]            first;
    logic [15:0]            last;
    logic [23:0]            spacing;
    logic                   fin;
  } job_t;

  function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
    logic signed [31:0] t;
    case (i)
      5'd0: t = 32'sd2949120;   5'd1: t = 32'sd1740967;
      5'd2: t = 32'sd919879;    5'd3: t = 32'sd466945;
      5'd4: t = 32'sd234379;    5'd5: t = 32'sd117304;
      5'd6: t = 32'sd58666;     5'd7: t = 32'sd29335;
      5'd8: t = 32'sd14668;     5'd9: t = 32'sd7334;
      5'd10: t = 32'sd3667;     5'd11: t = 32'sd1833;
      5'd12: t = 32'sd917;      5'd13: t = 32'sd458;
      5'd14: t = 32'sd229;      5'd15: t = 32'sd115;
      5'd16: t = 32'sd57;       5'd17: t = 32'sd29;
      5'd18: t = 32'sd14;       5'd19: t = 32'sd7;
      5'd20: t = 32'sd4;        5'd21: t = 32'sd2;
      5'd22: t = 32'sd1;
      default: t = 32'sd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

FILE: sv/lbsa_front.sv
`default_nettype none
module lbsa_front import lbsa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      stall_o,
  input  wire logic signed [SW-1:0] bin_real_i,
  input  wire logic signed [SW-1:0] bin_imag_i,
  input  wire logic [4:0]           log_base_i,
  input  wire logic [16:0]          num_bins_i,
  input  wire logic [23:0]          spacing_i,
  output logic                      job_valid_o,
  input  wire logic                 job_stall_i,
  output job_t                      job_o
);
  localparam logic signed [SUMW:0] SMAX = {2'b00, {(SUMW-1){1'b1}}};
  localparam logic signed [SUMW:0] SMIN = {2'b11, {(SUMW-1){1'b0}}};

  logic [16:0] pos_q, begin_q, width_q;
  logic [7:0]  cnt_q;
  logic signed [SUMW-1:0] sr_q, si_q;

  logic [4:0]  b;
  logic [16:0] nb;
  logic signed [SUMW:0] ar, ai;
  logic signed [SUMW-1:0] nr, ni;
  logic fin, done, take;
  logic [17:0] pos1, endp;
  logic [8:0]  bb;
  logic [21:0] w;

  assign b  = (log_base_i < 5'd2) ? 5'd2 : (log_base_i > 5'd16 ? 5'd16 : log_base_i);
  assign nb = (num_bins_i < 17'd2) ? 17'd2 :
              ((num_bins_i > 17'(MAX_BINS)) ? 17'(MAX_BINS) : num_bins_i);
  assign bb = 9'(b) * 9'(b);
  assign stall_o = job_valid_o && job_stall_i;
  assign take = valid_i && !stall_o;
  assign ar = SUMW'(0) + sr_q + (SUMW+1)'(bin_real_i);
  assign ai = SUMW'(0) + si_q + (SUMW+1)'(bin_imag_i);
  assign nr = (ar > SMAX) ? SMAX[SUMW-1:0] : (ar < SMIN ? SMIN[SUMW-1:0] : ar[SUMW-1:0]);
  assign ni = (ai > SMAX) ? SMAX[SUMW-1:0] : (ai < SMIN ? SMIN[SUMW-1:0] : ai[SUMW-1:0]);
  assign pos1 = 18'(pos_q) + 18'd1;
  assign endp = 18'(begin_q) + 18'(width_q);
  assign fin  = pos1 >= 18'(nb);
  assign done = (pos_q != 17'd0) && (fin || pos1 >= endp);
  assign w = 22'(width_q) * 22'(b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; begin_q <= 17'd1; width_q <= 17'd1; cnt_q <= '0;
      sr_q <= '0; si_q <= '0; job_valid_o <= 1'b0;
    end else begin
      if (!job_stall_i) job_valid_o <= 1'b0;
      if (take) begin
        if (pos_q == 17'd0) begin
          pos_q <= 17'd1;
        end else if (!done) begin
          pos_q <= pos1[16:0]; sr_q <= nr; si_q <= ni;
        end else begin
          job_valid_o   <= 1'b1;
          job_o.sr      <= nr;
          job_o.si      <= ni;
          job_o.count   <= 17'(pos1 - 18'(begin_q));
          job_o.first   <= begin_q[15:0];
          job_o.last    <= pos_q[15:0];
          job_o.spacing <= spacing_i;
          job_o.fin     <= fin;
          sr_q <= '0; si_q <= '0;
          if (fin) begin
            pos_q <= '0; begin_q <= 17'd1; width_q <= 17'd1; cnt_q <= '0;
          end else begin
            pos_q <= pos1[16:0]; begin_q <= pos1[16:0];
            if (9'(cnt_q) + 9'd1 >= bb) begin
              cnt_q <= '0;
              width_q <= (w > 22'(nb)) ? nb : w[16:0];
            end else begin
              cnt_q <= cnt_q + 8'd1;
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/lbsa_back.sv
`default_nettype none
module lbsa_back import lbsa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_stall_o,
  input  wire job_t        job_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [23:0]      mean_magnitude_o,
  output logic [15:0]      phase_deg_q7_o,
  output logic [39:0]      centre_freq_q8_o,
  output logic [15:0]      first_bin_o,
  output logic [15:0]      last_bin_o,
  output logic             final_slice_o
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_SQRT, S_CORD, S_OUT} state_e;
  state_e st_q;
  job_t   j_q;
  logic [39:0] nr_q, ni_q, qr_q, qi_q, rr_q, ri_q;
  logic [5:0]  k_q;
  logic [16:0] n17;
  logic [97:0] sq_q;
  logic [48:0] root_q, rem_q;
  logic signed [43:0] cx_q, cy_q;
  logic signed [31:0] z_q, base_q;
  logic        axis_q;
  logic [39:0] fr_q;

  logic [40:0] tr, ti;
  logic [50:0] trem;
  logic [47:0] sqr_re, sqr_im;
  logic [16:0] fsum;
  logic [40:0] fq;
  logic signed [33:0] zr;
  logic [4:0] ki;

  assign n17 = j_q.count;
  assign tr = {rr_q, nr_q[39]} - 41'(n17);
  assign ti = {ri_q, ni_q[39]} - 41'(n17);
  assign trem = {rem_q, sq_q[97:96]} - {root_q, 2'b01};
  assign ki = k_q[4:0];
  assign job_stall_o = (st_q != S_IDLE);
  // the rounded mean never exceeds 2^23, so 24 quotient bits carry it
  assign sqr_re = 48'(qr_q[23:0]) * 48'(qr_q[23:0]);
  assign sqr_im = 48'(qi_q[23:0]) * 48'(qi_q[23:0]);
  assign fsum = 17'(job_i.first) + 17'(job_i.last);
  assign fq = 41'(job_i.spacing) * 41'(fsum) + 41'd1;
  assign zr = (34'(base_q) + 34'(z_q) + 34'sd256) >>> 9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; valid_o <= 1'b0; k_q <= '0;
    end else begin
      if (valid_o && !stall_i) valid_o <= 1'b0;
      case (st_q)
        S_IDLE: if (job_valid_i) begin
          j_q <= job_i;
          // magnitudes plus half count, for round-half-away division
          nr_q <= (job_i.sr[39] ? 40'(-job_i.sr) : 40'(job_i.sr)) + 40'(job_i.count[16:1]);
          ni_q <= (job_i.si[39] ? 40'(-job_i.si) : 40'(job_i.si)) + 40'(job_i.count[16:1]);
          rr_q <= '0; ri_q <= '0; qr_q <= '0; qi_q <= '0; k_q <= '0;
          fr_q <= fq[40:1];
          st_q <= S_DIV;
        end
        S_DIV: begin
          rr_q <= tr[40] ? {rr_q[38:0], nr_q[39]} : tr[39:0];
          ri_q <= ti[40] ? {ri_q[38:0], ni_q[39]} : ti[39:0];
          qr_q <= {qr_q[38:0], !tr[40]};
          qi_q <= {qi_q[38:0], !ti[40]};
          nr_q <= {nr_q[38:0], 1'b0};
          ni_q <= {ni_q[38:0], 1'b0};
          k_q <= k_q + 6'd1;
          if (k_q == 6'd39) begin k_q <= '0; st_q <= S_MUL; end
        end
        S_MUL: begin
          sq_q <= 98'(sqr_re) + 98'(sqr_im);
          root_q <= '0; rem_q <= '0; k_q <= '0;
          cx_q <= j_q.sr[39] ? 44'(-j_q.sr) : 44'(j_q.sr);
          cy_q <= j_q.sr[39] ? 44'(-j_q.si) : 44'(j_q.si);
          z_q <= '0;
          axis_q <= (j_q.sr == 0) || (j_q.si == 0);
          if (j_q.si == 0) base_q <= j_q.sr[39] ? 32'sd11796480 : 32'sd0;
          else if (j_q.sr == 0) base_q <= j_q.si[39] ? -32'sd5898240 : 32'sd5898240;
          else if (j_q.sr[39]) base_q <= j_q.si[39] ? -32'sd11796480 : 32'sd11796480;
          else base_q <= 32'sd0;
          st_q <= S_SQRT;
        end
        S_SQRT: begin
          if (!trem[50]) begin
            rem_q <= trem[48:0]; root_q <= {root_q[47:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], sq_q[97:96]}; root_q <= {root_q[47:0], 1'b0};
          end
          sq_q <= {sq_q[95:0], 2'b00};
          k_q <= k_q + 6'd1;
          if (k_q == 6'd48) begin k_q <= '0; st_q <= S_CORD; end
        end
        S_CORD: begin
          if (!axis_q) begin
            if (cy_q > 0) begin
              cx_q <= cx_q + (cy_q >>> ki); cy_q <= cy_q - (cx_q >>> ki);
              z_q <= z_q + atan_q16(ki);
            end else begin
              cx_q <= cx_q - (cy_q >>> ki); cy_q <= cy_q + (cx_q >>> ki);
              z_q <= z_q - atan_q16(ki);
            end
          end
          if (k_q == 6'(CSTEPS-1)) begin
            if (rem_q > root_q) root_q <= root_q + 49'd1;
            st_q <= S_OUT;
          end
          k_q <= k_q + 6'd1;
        end
        S_OUT: if (!valid_o || !stall_i) begin
          valid_o <= 1'b1;
          mean_magnitude_o <= (root_q > 49'hFFFFFF) ? 24'hFFFFFF : root_q[23:0];
          phase_deg_q7_o <= (zr > 34'sd23040) ? 16'sd23040 :
                            (zr < -34'sd23040) ? -16'sd23040 : zr[15:0];
          centre_freq_q8_o <= fr_q;
          first_bin_o <= j_q.first;
          last_bin_o <= j_q.last;
          final_slice_o <= j_q.fin;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/log_band_spectrum_averager.sv
`default_nettype none
// Log-band spectrum averager.
// Bins stream in on bin_real_i/bin_imag_i (valid_i/stall_o), bin 0 first up to
// num_bins-1; bin 0 is dropped. Bins 1 onward are summed into slices whose
// widths grow by log_base after log_base^2 slices of each width. At each slice
// end one request leaves on valid_o/stall_i: mean magnitude, phase, centre
// frequency, bounds and final flag.
// The front accumulates one bin per cycle while its one-entry queue is not
// held full by a busy back, and hands each finished slice to that queue. The
// back takes a slice only when idle and works it out in steps (40 divider
// steps, multiply, 49 square-root steps, 16 CORDIC steps, output), so the
// width-one slices are bound by the back's iterative divider and square root.
// Reset returns registers to log_base 2, num_bins 1024, spacing 6000 and the
// slice state to the start of a spectrum. A stalled receiver holds the output
// register, then the back, then the queue, and finally stalls the input.
// Write configuration only while idle through cfg_we_i/cfg_addr_i/cfg_data_i.
module log_band_spectrum_averager import lbsa_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      stall_o,
  input  wire logic signed [23:0]   bin_real_i,
  input  wire logic signed [23:0]   bin_imag_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_addr_i,
  input  wire logic [23:0]          cfg_data_i,
  output logic                      valid_o,
  input  wire logic                 stall_i,
  output logic [23:0]               mean_magnitude_o,
  output logic signed [15:0]        phase_deg_q7_o,
  output logic [39:0]               centre_freq_q8_o,
  output logic [15:0]               first_bin_o,
  output logic [15:0]               last_bin_o,
  output logic                      final_slice_o
);
  logic [4:0]  log_base_q;
  logic [16:0] num_bins_q;
  logic [23:0] spacing_q;
  logic        jv, js;
  job_t        job;

  // hold config registers; bits beyond a register's width are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_base_q <= 5'd2; num_bins_q <= 17'd1024; spacing_q <= 24'd6000;
    end else if (cfg_we_i) begin
      case (5'(cfg_addr_i))
        REG_LOG_BASE: log_base_q <= cfg_data_i[4:0];
        REG_NUM_BINS: num_bins_q <= cfg_data_i[16:0];
        REG_SPACING:  spacing_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lbsa_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .bin_real_i, .bin_imag_i,
    .log_base_i(log_base_q), .num_bins_i(num_bins_q), .spacing_i(spacing_q),
    .job_valid_o(jv), .job_stall_i(js), .job_o(job)
  );

  lbsa_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_stall_o(js), .job_i(job),
    .valid_o, .stall_i, .mean_magnitude_o, .phase_deg_q7_o,
    .centre_freq_q8_o, .first_bin_o, .last_bin_o, .final_slice_o
  );

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> first_bin_o <= last_bin_o) else $error("slice bounds reversed");
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(phase_deg_q7_o) <= 16'sd23040 &&
                 $signed(phase_deg_q7_o) >= -16'sd23040)) else $error("phase range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(last_bin_o)) else $error("result lost");
endmodule
`default_nettype wire

FILE: test/tb_log_band_spectrum_averager.sv
`timescale 1ns / 1ps
module tb_log_band_spectrum_averager;
  import lbsa_pkg::*;

  // Quiet cycles before a register write and at the end; enough to cover one
  // slice in flight through the back end, with margin.
  localparam int SETTLE = 400;
  // Cycles with no request moving on either side before the run is abandoned.
  localparam int STUCK_LIMIT = 20000;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;
  localparam longint DEG180 = 64'sd11796480;
  localparam longint DEG90 = 64'sd5898240;
  localparam longint unsigned FREQ_HI = 64'd1099511627775;

  typedef enum logic [1:0] {ST_BIN, ST_REG, ST_MODE, ST_HOLD} stim_kind_e;

  typedef struct {
    stim_kind_e kind;
    longint a;
    longint b;
  } stim_t;

  typedef struct {
    logic [23:0] mag;
    logic signed [15:0] phase;
    logic [39:0] freq;
    logic [15:0] first;
    logic [15:0] last;
    logic fin;
  } band_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [23:0] bin_real_i = '0;
  logic signed [23:0] bin_imag_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [23:0] mean_magnitude_o;
  logic signed [15:0] phase_deg_q7_o;
  logic [39:0] centre_freq_q8_o;
  logic [15:0] first_bin_o;
  logic [15:0] last_bin_o;
  logic final_slice_o;

  log_band_spectrum_averager uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(valid_i), .stall_o(stall_o),
    .bin_real_i(bin_real_i), .bin_imag_i(bin_imag_i),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_data_i(cfg_data_i),
    .valid_o(valid_o), .stall_i(stall_i),
    .mean_magnitude_o(mean_magnitude_o), .phase_deg_q7_o(phase_deg_q7_o),
    .centre_freq_q8_o(centre_freq_q8_o), .first_bin_o(first_bin_o),
    .last_bin_o(last_bin_o), .final_slice_o(final_slice_o)
  );

  always #10 clk_i = ~clk_i;

  // Scoreboard state.
  stim_t stimulus[$];
  band_t bands_due[$];
  int errors = 0;
  int bins_sent = 0;
  int bands_seen = 0;
  int finals_seen = 0;
  int reg_writes = 0;
  int quiet_in = 0;
  int quiet_out = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // Mirror of the block: registers as written, then slice state.
  logic [4:0] base_reg;
  logic [16:0] bins_reg;
  logic [23:0] spacing_reg;
  int unsigned bin_pos;
  int unsigned slice_lo;
  int unsigned slice_w;
  int unsigned slices_done;
  longint acc_re;
  longint acc_im;

  longint atan_deg_q16[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
    errors++;
  endtask

  function automatic longint clamp_sum(input longint v);
    return (v > SUM_HI) ? SUM_HI : ((v < SUM_LO) ? SUM_LO : v);
  endfunction

  // Mean with ties away from zero.
  function automatic longint mean_of(input longint s, input longint unsigned n);
    longint unsigned a;
    longint unsigned q;
    a = (s < 0) ? longint'(-s) : longint'(s);
    q = (a + n / 2) / n;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_rounded(input longint unsigned x);
    longint unsigned r;
    longint unsigned bv;
    r = 0;
    bv = 64'h1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= r + bv) begin
        x = x - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  // Angle of the slice sum in Q7 degrees: exact on the axes, otherwise fold
  // the left half plane and rotate toward the x axis.
  function automatic logic signed [15:0] angle_q7(input longint x, input longint y);
    longint z;
    longint org;
    longint xs;
    longint ys;
    z = 0;
    org = 0;
    if (y == 0) begin
      org = (x < 0) ? DEG180 : 0;
    end else if (x == 0) begin
      org = (y > 0) ? DEG90 : -DEG90;
    end else begin
      if (x < 0) begin
        org = (y >= 0) ? DEG180 : -DEG180;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CSTEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_deg_q16[i];
        end else begin
          x -= ys; y += xs; z -= atan_deg_q16[i];
        end
      end
    end
    z = (org + z + 256) >>> 9;
    if (z > 23040) z = 23040;
    if (z < -23040) z = -23040;
    return z[15:0];
  endfunction

  // Fold one accepted bin into the running slice; queue a band when it closes.
  task automatic accumulate_bin(input logic signed [23:0] re, input logic signed [23:0] im);
    int unsigned b;
    int unsigned nb;
    int unsigned cnt;
    longint mr;
    longint mi;
    longint unsigned mag;
    longint unsigned fq;
    longint unsigned w;
    logic fin;
    band_t band;
    b = (base_reg < 2) ? 2 : ((base_reg > 16) ? 16 : base_reg);
    nb = (bins_reg < 2) ? 2 : ((bins_reg > MAX_BINS) ? MAX_BINS : bins_reg);
    if (bin_pos == 0) begin
      bin_pos = 1;
      return;
    end
    acc_re = clamp_sum(acc_re + longint'(re));
    acc_im = clamp_sum(acc_im + longint'(im));
    fin = (bin_pos + 1 >= nb);
    if (!fin && bin_pos + 1 < slice_lo + slice_w) begin
      bin_pos++;
      return;
    end
    cnt = bin_pos + 1 - slice_lo;
    mr = mean_of(acc_re, cnt);
    mi = mean_of(acc_im, cnt);
    mag = root_rounded(longint'(mr * mr) + longint'(mi * mi));
    if (mag > 64'hFFFFFF) mag = 64'hFFFFFF;
    fq = (longint'(spacing_reg) * (longint'(slice_lo) + longint'(bin_pos)) + 1) >> 1;
    if (fq > FREQ_HI) fq = FREQ_HI;
    band.mag = mag[23:0];
    band.phase = angle_q7(acc_re, acc_im);
    band.freq = fq[39:0];
    band.first = slice_lo[15:0];
    band.last = bin_pos[15:0];
    band.fin = fin;
    bands_due.insert(bands_due.size(), band);
    acc_re = 0;
    acc_im = 0;
    if (fin) begin
      bin_pos = 0; slice_lo = 1; slice_w = 1; slices_done = 0;
    end else begin
      bin_pos++;
      slice_lo = bin_pos;
      slices_done++;
      if (slices_done >= b * b) begin
        w = longint'(slice_w) * b;
        slices_done = 0;
        slice_w = (w > nb) ? nb : int'(w);
      end
    end
  endtask

  function automatic void mirror_write(input longint idx, input longint val);
    if (idx == REG_LOG_BASE) base_reg = val[4:0];
    else if (idx == REG_NUM_BINS) bins_reg = val[16:0];
    else if (idx == REG_SPACING) spacing_reg = val[23:0];
  endfunction

  // Driver: hold a stalled request, otherwise take the next queue entry.
  always @(posedge clk_i) begin
    logic nv;
    logic nwe;
    stim_t e;
    if (rst_ni) begin
      quiet_in++;
      if (valid_i && !stall_o) begin
        accumulate_bin(bin_real_i, bin_imag_i);
        bins_sent++;
        quiet_in = 0;
      end
      nv = valid_i && stall_o;
      nwe = 1'b0;
      if (!nv && stimulus.size() != 0) begin
        e = stimulus[0];
        case (e.kind)
          ST_BIN: begin
            if ($urandom_range(99) >= idle_pct) begin
              nv = 1'b1;
              bin_real_i <= e.a[23:0];
              bin_imag_i <= e.b[23:0];
              void'(stimulus.pop_front());
            end
          end
          ST_REG: begin
            // Write only once the back end has drained.
            if (bands_due.size() == 0 && quiet_in >= SETTLE && quiet_out >= SETTLE) begin
              nwe = 1'b1;
              cfg_addr_i <= e.a[1:0];
              cfg_data_i <= e.b[23:0];
              mirror_write(e.a, e.b);
              reg_writes++;
              quiet_in = SETTLE;
              void'(stimulus.pop_front());
            end
          end
          ST_MODE: begin
            idle_pct = int'(e.a);
            stall_pct = int'(e.b);
            void'(stimulus.pop_front());
          end
          default: begin
            if (bands_due.size() == 0) void'(stimulus.pop_front());
          end
        endcase
      end
      valid_i <= nv;
      cfg_we_i <= nwe;
    end
  end

  // Monitor: check each accepted band against the oldest expectation.
  always @(posedge clk_i) begin
    band_t want;
    if (rst_ni) begin
      quiet_out++;
      if (valid_o && !stall_i) begin
        quiet_out = 0;
        bands_seen++;
        if (final_slice_o) finals_seen++;
        if (bands_due.size() == 0) begin
          flag_mismatch("unexpected band, first_bin", first_bin_o, -1);
        end else begin
          want = bands_due.pop_front();
          if (mean_magnitude_o !== want.mag)
            flag_mismatch("mean_magnitude", mean_magnitude_o, want.mag);
          if (phase_deg_q7_o !== want.phase)
            flag_mismatch("phase_deg_q7", phase_deg_q7_o, want.phase);
          if (centre_freq_q8_o !== want.freq)
            flag_mismatch("centre_freq_q8", centre_freq_q8_o, want.freq);
          if (first_bin_o !== want.first) flag_mismatch("first_bin", first_bin_o, want.first);
          if (last_bin_o !== want.last) flag_mismatch("last_bin", last_bin_o, want.last);
          if (final_slice_o !== want.fin)
            flag_mismatch("final_slice", final_slice_o, want.fin);
        end
      end
      stall_i <= ($urandom_range(99) < stall_pct);
      // Watchdog: nothing moved on either side for too long.
      if (quiet_in > STUCK_LIMIT && quiet_out > STUCK_LIMIT) begin
        $display("[log_band_spectrum_averager] ERROR");
        $finish;
      end
    end
  end

  function automatic longint pick_sample();
    case ($urandom_range(9))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      3: return longint'($urandom_range(2)) - 1;
      default: return longint'(signed'(24'($urandom)));
    endcase
  endfunction

  function automatic void queue_stimulus(input stim_t s);
    stimulus.insert(stimulus.size(), s);
  endfunction

  function automatic void add_bin(input longint re, input longint im);
    queue_stimulus('{ST_BIN, re, im});
  endfunction

  function automatic void add_regs(input longint b, input longint nb, input longint sp);
    queue_stimulus('{ST_REG, REG_LOG_BASE, b});
    queue_stimulus('{ST_REG, REG_NUM_BINS, nb});
    queue_stimulus('{ST_REG, REG_SPACING, sp});
  endfunction

  function automatic void add_mode(input int idle, input int stall);
    queue_stimulus('{ST_MODE, idle, stall});
  endfunction

  initial begin
    base_reg = 5'd2;
    bins_reg = 17'd1024;
    spacing_reg = 24'd6000;
    bin_pos = 0; slice_lo = 1; slice_w = 1; slices_done = 0;
    acc_re = 0; acc_im = 0;

    // Directed: reset settings, field extremes, every quadrant and both axes.
    add_mode(0, 0);
    add_bin(123, -456);
    add_bin(8388607, 8388607);
    add_bin(-8388608, -8388608);
    add_bin(0, 0);
    add_bin(8388607, 0);
    add_bin(-8388608, 0);
    add_bin(0, 8388607);
    add_bin(0, -8388608);
    add_bin(-8388608, 8388607);
    add_bin(8388607, -8388608);
    add_bin(-1, 1);
    add_bin(1, -1);
    add_bin(-3, -5);
    add_bin(4, 7);
    add_bin(-8388608, -8388608);
    add_bin(-8388608, -1);
    // Shrink the bin count below the position: the next bin closes the spectrum.
    // Out-of-range base clamps; zero spacing gives zero frequency.
    add_regs(0, 5, 0);
    add_bin(1000, -1000);
    add_bin(5, 5);
    add_bin(-7, 9);
    add_bin(11, 0);
    add_bin(0, -12);

    // Random phases: sweep settings, idling patterns and the sender pause.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin add_regs(2, 40, 6000); add_mode(0, 0); end
        1: begin add_regs(3, 2, 1); add_mode(82, 0); end
        2: begin add_regs(16, 300, 16777215); add_mode(0, 82); end
        3: begin add_regs(1, 70000, 0); add_mode(29, 29); end
        4: begin add_regs(31, 1, 12345); add_mode(0, 0); end
        5: begin add_regs(5, 65536, 1); add_mode(82, 0); end
        6: begin add_regs(2, 131071, 16777215); add_mode(0, 82); end
        default: begin add_regs(4, 97, 777); add_mode(29, 29); end
      endcase
      for (int k = 0; k < 154; k++) begin
        add_bin(pick_sample(), pick_sample());
        if (k == 77) queue_stimulus('{ST_HOLD, 0, 0});
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus.size() != 0 || bands_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("bins sent %0d, bands checked %0d (%0d spectrum ends), register writes %0d",
             bins_sent, bands_seen, finals_seen, reg_writes);
    $display("settings swept across clamped, extreme and mid-spectrum changes");
    if (errors == 0 && bands_due.size() == 0) begin
      $display("[log_band_spectrum_averager] OK");
    end else begin
      $display("[log_band_spectrum_averager] ERROR");
    end
    $finish;
  end
endmodule
